@@ src/bha_pkg.sv @@
// ----------------------------------------------------------------------------
// bha_pkg: shared types and constants for the bitmap handle allocator
// Holds the controller state type, the command and status groups between
// controller and datapath, opcodes and the lowest-clear-bit encoder.
// ----------------------------------------------------------------------------
package bha_pkg;

  localparam int unsigned BitmapWordsDefault = 64;
  localparam int unsigned HandleWordLimit    = 64;
  localparam int unsigned WordBits           = 64;
  localparam int unsigned WordsW             = 7;
  localparam int unsigned HandleW            = 12;
  localparam int unsigned FreeIdW            = 13;
  localparam int unsigned BitIdxW            = 6;

  localparam logic [WordsW-1:0]  WORDS_IN_USE_RESET = 7'd64;
  localparam logic [FreeIdW-1:0] NO_HANDLE_ID       = 13'd4096;
  localparam logic [WordBits-1:0] FULL_WORD         = '1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC_WR,
    ST_FREE_RD,
    ST_FREE_WR
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic alloc_wr;
    logic free_rd;
    logic free_wr;
    logic fail_resp;
  } bha_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic found;
    logic scan_end;
  } bha_stat_t;

  // Index of the lowest clear bit; only used on words that are not full
  function automatic logic [BitIdxW-1:0] lowest_clear(input logic [WordBits-1:0] w);
    logic [BitIdxW-1:0] r;
    r = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!w[i]) r = BitIdxW'(i);
    end
    return r;
  endfunction

endpackage

@@ src/bha_ram.sv @@
// ----------------------------------------------------------------------------
// bha_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bha_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/bha_ctrl.sv @@
// ----------------------------------------------------------------------------
// bha_ctrl: allocator controller
// Sequences scan, read-modify-write and response steps for each item.
// ----------------------------------------------------------------------------
module bha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               opcode,
  input  bha_pkg::bha_stat_t stat,
  output bha_pkg::bha_cmd_t  cmd,
  output logic               busy
);

  import bha_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (opcode == OP_FREE) ? ST_FREE_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.found) begin
          state_next = ST_ALLOC_WR;
        end else if (stat.scan_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_ALLOC_WR: state_next = ST_IDLE;
      ST_FREE_RD:  state_next = ST_FREE_WR;
      ST_FREE_WR:  state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_SCAN: begin
        cmd.scan      = 1'b1;
        cmd.fail_resp = !stat.found && stat.scan_end;
      end
      ST_ALLOC_WR: cmd.alloc_wr = 1'b1;
      ST_FREE_RD:  cmd.free_rd  = 1'b1;
      ST_FREE_WR:  cmd.free_wr  = 1'b1;
      default:     busy = 1'b0;
    endcase
  end

endmodule

@@ src/bha_dp.sv @@
// ----------------------------------------------------------------------------
// bha_dp: allocator datapath
// Bitmap RAM with per-word valid bits, scan pointer, free-bit encoder,
// word-count register and result registers.
// ----------------------------------------------------------------------------
module bha_dp #(
  parameter int unsigned BITMAP_WORDS = bha_pkg::BitmapWordsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bha_pkg::bha_cmd_t             cmd,
  output bha_pkg::bha_stat_t            stat,
  input  logic [bha_pkg::FreeIdW-1:0]   free_handle_id,
  input  logic                          cfg_we,
  input  logic [bha_pkg::WordsW-1:0]    cfg_data,
  output logic                          done,
  output logic [bha_pkg::HandleW-1:0]   allocated_handle,
  output logic                          status
);

  import bha_pkg::*;

  // Handles are 12 bits wide, so only the first 64 words are reachable
  localparam int unsigned DEPTH = (BITMAP_WORDS < HandleWordLimit) ?
                                  BITMAP_WORDS : HandleWordLimit;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WordsW-1:0]   words_in_use;
  logic [WordsW-1:0]   act_words;
  logic [WordsW-1:0]   act_words_cur;
  logic [WordsW-1:0]   scan_idx;
  logic                chk_vld;
  logic [AW-1:0]       chk_idx;
  logic                rd_live;
  logic [DEPTH-1:0]    valid;
  logic                free_ok;
  logic [AW-1:0]       free_idx;
  logic [BitIdxW-1:0]  free_bit;
  logic [AW-1:0]       found_idx;
  logic [BitIdxW-1:0]  found_bit;
  logic [WordBits-1:0] found_word;

  logic                issue;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [WordBits-1:0] wr_data;
  logic [WordBits-1:0] ram_rdata;
  logic [WordBits-1:0] word;
  logic [FreeIdW-1:0]  handle_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= WORDS_IN_USE_RESET;
    end else if (cfg_we) begin
      words_in_use <= cfg_data;
    end
  end

  assign act_words_cur = (words_in_use > WordsW'(DEPTH)) ? WordsW'(DEPTH) : words_in_use;
  assign handle_limit  = {act_words_cur, BitIdxW'(0)};

  // Never-written words read as all free
  assign word = rd_live ? ram_rdata : '0;

  assign issue         = cmd.scan && (scan_idx < act_words);
  assign stat.found    = chk_vld && (word != FULL_WORD);
  assign stat.scan_end = !chk_vld && (scan_idx >= act_words);

  assign rd_en   = issue || (cmd.free_rd && free_ok);
  assign rd_addr = cmd.free_rd ? free_idx : scan_idx[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = found_idx;
    wr_data = found_word | (WordBits'(1) << found_bit);
    if (cmd.free_wr) begin
      wr_en   = free_ok;
      wr_addr = free_idx;
      wr_data = word & ~(WordBits'(1) << free_bit);
    end else if (cmd.alloc_wr) begin
      wr_en = 1'b1;
    end
  end

  bha_ram #(
    .WIDTH (WordBits),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld  <= 1'b0;
      scan_idx <= '0;
    end else if (cmd.accept) begin
      chk_vld  <= 1'b0;
      scan_idx <= '0;
    end else if (cmd.scan) begin
      chk_vld <= issue;
      if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_live <= valid[rd_addr];
    end
    if (issue) begin
      chk_idx <= scan_idx[AW-1:0];
    end
    if (cmd.accept) begin
      act_words <= act_words_cur;
      free_ok   <= (free_handle_id != NO_HANDLE_ID) && (free_handle_id < handle_limit);
      free_idx  <= free_handle_id[BitIdxW +: AW];
      free_bit  <= free_handle_id[BitIdxW-1:0];
    end
    if (cmd.scan && stat.found) begin
      found_idx  <= chk_idx;
      found_bit  <= lowest_clear(word);
      found_word <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.alloc_wr || cmd.free_wr || cmd.fail_resp;
    end
  end

  always_ff @(posedge clk) begin
    allocated_handle <= cmd.alloc_wr ? {BitIdxW'(found_idx), found_bit} : '0;
    status           <= cmd.fail_resp ? STATUS_FULL : STATUS_DONE;
  end

endmodule

@@ src/bitmap_handle_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_handle_allocator: find-first-zero handle allocator
// Bitmap of 64-bit words, one bit per handle; allocate sets the lowest
// clear bit of the first non-full word, free clears a handle's bit.
// ----------------------------------------------------------------------------
// Pulse start with opcode and free_handle_id while busy is low; the item is
// taken at that edge and busy rises. Exactly one result follows: done is
// high for one cycle with allocated_handle and status, and the receiver must
// take it then, as nothing holds it. A new item may start in the cycle done
// is shown. An allocate scans the active words in order until one is not
// full, then writes that word back with the bit set; a failed allocate
// scans every active word. A free of a valid handle reads its word, then
// writes it back with the bit cleared. The scan is paced by the single read
// port of the bitmap RAM, which yields one word per cycle to the scan.
// words_in_use (cfg_data, written with cfg_we) is sampled when an item is
// taken; write it only while busy is low. After reset every handle is free
// at once: per-word valid bits stand in for the cleared RAM, so no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module bitmap_handle_allocator #(
  parameter int unsigned BITMAP_WORDS = bha_pkg::BitmapWordsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode,
  input  logic [bha_pkg::FreeIdW-1:0]  free_handle_id,
  input  logic                         cfg_we,
  input  logic [bha_pkg::WordsW-1:0]   cfg_data,
  output logic                         done,
  output logic [bha_pkg::HandleW-1:0]  allocated_handle,
  output logic                         status
);

  import bha_pkg::*;

  bha_cmd_t  cmd;
  bha_stat_t stat;

  // Controller: decide the step for each cycle of an item
  bha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .opcode(opcode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: bitmap storage, scan pointer and result registers
  bha_dp #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .free_handle_id  (free_handle_id),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .done            (done),
    .allocated_handle(allocated_handle),
    .status          (status)
  );

endmodule

@@ src/bha_checker.sv @@
// ----------------------------------------------------------------------------
// bha_checker: port-level checks for the bitmap handle allocator
// Watches the top-level ports and ties item acceptance to results.
// ----------------------------------------------------------------------------
module bha_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [bha_pkg::HandleW-1:0]  allocated_handle,
  input logic                         status
);

  import bha_pkg::*;

  // A taken item raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item taken but busy did not rise");

  // A result appears only once the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // A result ends an item: the block was busy just before
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a preceding item");

  // A full status carries no handle
  a_full_no_handle: assert property (@(posedge clk) disable iff (rst)
    done && (status == STATUS_FULL) |-> allocated_handle == '0)
    else $error("full status with nonzero handle");

endmodule

bind bitmap_handle_allocator bha_checker u_bha_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .allocated_handle(allocated_handle),
  .status          (status)
);
